// ----- hw/rtl/utf8sd_pkg.sv -----
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; every other file of the decoder imports this package.
package utf8sd_pkg;

    localparam int BYTE_W     = 8;
    localparam int CP_W       = 21;
    localparam int UNITS_W    = 16;
    localparam int LEN_W      = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Result queue depth; must be a power of two so the pointers wrap freely.
    localparam int QDEPTH = 4;

    // Register indexes, taken from paddr[CFG_ADDR_W-1].
    localparam logic REG_NARROW   = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    localparam logic [UNITS_W-1:0] CAPACITY_RESET = 16'hFFFF;

    localparam logic [CP_W-1:0] BAD_MARK     = 21'd63;
    localparam logic [CP_W-1:0] TWO_MIN      = 21'h00080;
    localparam logic [CP_W-1:0] TWO_MAX      = 21'h007FF;
    localparam logic [CP_W-1:0] THREE_MIN    = 21'h00800;
    localparam logic [CP_W-1:0] THREE_MAX    = 21'h0FFFD;
    localparam logic [CP_W-1:0] FOUR_MIN     = 21'h10000;
    localparam logic [CP_W-1:0] FOUR_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_HI_LO   = 21'h0D800;
    localparam logic [CP_W-1:0] SURR_HI_MID  = 21'h0DB7F;
    localparam logic [CP_W-1:0] SURR_PRIV_LO = 21'h0DB80;
    localparam logic [CP_W-1:0] SURR_HI_HI   = 21'h0DBFF;
    localparam logic [CP_W-1:0] SURR_LO_LO   = 21'h0DC00;
    localparam logic [CP_W-1:0] SURR_LO_MID  = 21'h0DF80;
    localparam logic [CP_W-1:0] SURR_LO_HI   = 21'h0DFFF;

    typedef struct packed {
        logic               narrow_mode;
        logic [UNITS_W-1:0] capacity_units;
    } cfg_t;

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic               string_end;
        logic [UNITS_W-1:0] units_written;
        logic               last_of_run;
    } result_t;

    // Up to two results produced by one decoded byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ----- hw/rtl/utf8sd_if.sv -----
// Valid/ready channel interfaces for the decoder's byte input and result output.
// Depends on utf8sd_pkg for field widths.
interface utf8sd_byte_if;
    import utf8sd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface utf8sd_res_if;
    import utf8sd_pkg::*;

    logic               valid;
    logic               ready;
    logic [CP_W-1:0]    code_point;
    logic               string_end;
    logic [UNITS_W-1:0] units_written;
    logic               last_of_run;

    modport source (output valid, output code_point, output string_end,
                    output units_written, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input string_end,
                    input units_written, input last_of_run, output ready);
endinterface

// ----- hw/rtl/utf8sd_cfg.sv -----
// APB-style register block holding narrow_mode and capacity_units.
// Depends on utf8sd_pkg.
module utf8sd_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [utf8sd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [utf8sd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [utf8sd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                               pready,
    output utf8sd_pkg::cfg_t                   cfg
);
    import utf8sd_pkg::*;

    logic               narrow_reg;
    logic [UNITS_W-1:0] capacity_reg;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[CFG_ADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            narrow_reg   <= 1'b0;
            capacity_reg <= CAPACITY_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_NARROW:   narrow_reg   <= pwdata[0];
                REG_CAPACITY: capacity_reg <= pwdata[UNITS_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_NARROW:   prdata = {{(CFG_DATA_W-1){1'b0}}, narrow_reg};
            REG_CAPACITY: prdata = {{(CFG_DATA_W-UNITS_W){1'b0}}, capacity_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.narrow_mode    = narrow_reg;
    assign cfg.capacity_units = capacity_reg;

endmodule

// ----- hw/rtl/utf8sd_core.sv -----
// Byte input register, sequence state and single-pass decode into up to two results.
// Depends on utf8sd_pkg.
module utf8sd_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  utf8sd_pkg::cfg_t              cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [utf8sd_pkg::BYTE_W-1:0] in_byte,
    input  logic                          room,
    output utf8sd_pkg::push_t             push
);
    import utf8sd_pkg::*;

    logic               hold_valid_reg, hold_valid_next;
    logic [BYTE_W-1:0]  hold_byte_reg;
    logic [LEN_W-1:0]   bytes_pending_reg, bytes_pending_next;
    logic [LEN_W-1:0]   seq_len_reg, seq_len_next;
    logic [CP_W-1:0]    gathered_reg, gathered_next;
    logic [UNITS_W-1:0] given_count_reg, given_count_next;

    logic               fire;
    logic               accept;
    logic [BYTE_W-1:0]  b;
    logic [CP_W-1:0]    shifted;
    logic [LEN_W-1:0]   pend_dec;
    logic               g1_req, g1_bad, g1_emit;
    logic [CP_W-1:0]    g1_val, g1_cp;
    logic               lead_en;
    logic               l_end, l_req, l_bad, l_give, l_emit;
    logic [CP_W-1:0]    l_val, l_cp;
    logic [UNITS_W-1:0] count_mid;
    result_t            r1, r2;

    function automatic logic seq_bad(input logic [LEN_W-1:0] len, input logic [CP_W-1:0] v);
        logic bad;
        case (len)
            3'd2:    bad = !(v inside {[TWO_MIN:TWO_MAX]});
            3'd3:    bad = (v inside {SURR_HI_LO, SURR_HI_MID, SURR_PRIV_LO, SURR_HI_HI,
                                      SURR_LO_LO, SURR_LO_MID, SURR_LO_HI})
                           || !(v inside {[THREE_MIN:THREE_MAX]});
            3'd4:    bad = !(v inside {[FOUR_MIN:FOUR_MAX]});
            default: bad = 1'b1;
        endcase
        return bad;
    endfunction

    // Replacement mark for bad sequences, and for wide values in narrow mode.
    function automatic logic [CP_W-1:0] out_point(input logic bad, input logic narrow,
                                                  input logic [CP_W-1:0] v);
        return (bad || (narrow && (|v[CP_W-1:16]))) ? BAD_MARK : v;
    endfunction

    assign fire     = hold_valid_reg && room;
    assign in_ready = !hold_valid_reg || fire;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
            hold_valid_next = 1'b1;
        else if (fire)
            hold_valid_next = 1'b0;
        else
            hold_valid_next = hold_valid_reg;
    end

    always_comb
    begin
        b        = hold_byte_reg;
        shifted  = {gathered_reg[CP_W-7:0], b[5:0]};
        pend_dec = bytes_pending_reg - 3'd1;

        bytes_pending_next = bytes_pending_reg;
        seq_len_next       = seq_len_reg;
        gathered_next      = gathered_reg;
        g1_req  = 1'b0;
        g1_bad  = 1'b0;
        g1_val  = '0;
        lead_en = 1'b0;
        l_end   = 1'b0;
        l_req   = 1'b0;
        l_bad   = 1'b0;
        l_val   = '0;

        // Continuation path: a pending sequence either grows or is broken.
        if (bytes_pending_reg != '0)
        begin
            if (b[7:6] == 2'b10)
            begin
                gathered_next      = shifted;
                bytes_pending_next = pend_dec;
                if (pend_dec == '0)
                begin
                    g1_req        = 1'b1;
                    g1_val        = shifted;
                    g1_bad        = seq_bad(seq_len_reg, shifted);
                    seq_len_next  = '0;
                    gathered_next = '0;
                end
            end
            else
            begin
                // Broken sequence: one mark, then this byte starts over as a lead.
                bytes_pending_next = '0;
                seq_len_next       = '0;
                gathered_next      = '0;
                g1_req             = 1'b1;
                g1_bad             = 1'b1;
                lead_en            = 1'b1;
            end
        end
        else
        begin
            lead_en = 1'b1;
        end

        if (lead_en)
        begin
            if (b == '0)
            begin
                l_end              = 1'b1;
                bytes_pending_next = '0;
                seq_len_next       = '0;
                gathered_next      = '0;
            end
            else if (!b[7])
            begin
                l_req = 1'b1;
                l_val = {{(CP_W-BYTE_W){1'b0}}, b};
            end
            else if (!b[6])
            begin
                l_req = 1'b1;
                l_bad = 1'b1;
            end
            else
            begin
                if (!b[5])
                begin
                    seq_len_next  = 3'd2;
                    gathered_next = {{(CP_W-5){1'b0}}, b[4:0]};
                end
                else if (!b[4])
                begin
                    seq_len_next  = 3'd3;
                    gathered_next = {{(CP_W-4){1'b0}}, b[3:0]};
                end
                else if (!b[3])
                begin
                    seq_len_next  = 3'd4;
                    gathered_next = {{(CP_W-3){1'b0}}, b[2:0]};
                end
                else if (!b[2])
                begin
                    seq_len_next  = 3'd5;
                    gathered_next = '0;
                end
                else
                begin
                    seq_len_next  = 3'd6;
                    gathered_next = '0;
                end
                bytes_pending_next = seq_len_next - 3'd1;
            end
        end
    end

    // Capacity is checked for each point in order, so the second one sees the first.
    always_comb
    begin
        g1_cp     = out_point(g1_bad, cfg.narrow_mode, g1_val);
        g1_emit   = g1_req && (given_count_reg < cfg.capacity_units);
        count_mid = given_count_reg + {{(UNITS_W-1){1'b0}}, g1_emit};
        l_cp      = out_point(l_bad, cfg.narrow_mode, l_val);
        l_give    = l_req && (count_mid < cfg.capacity_units);
        l_emit    = l_end || l_give;

        if (l_end)
            given_count_next = '0;
        else
            given_count_next = count_mid + {{(UNITS_W-1){1'b0}}, l_give};

        r1.code_point    = g1_cp;
        r1.string_end    = 1'b0;
        r1.units_written = '0;
        r1.last_of_run   = !l_emit;

        r2.code_point    = l_end ? '0 : l_cp;
        r2.string_end    = l_end;
        r2.units_written = l_end ? count_mid : '0;
        r2.last_of_run   = 1'b1;

        push.count  = fire ? ({1'b0, g1_emit} + {1'b0, l_emit}) : 2'd0;
        push.first  = g1_emit ? r1 : r2;
        push.second = r2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg    <= 1'b0;
            bytes_pending_reg <= '0;
            seq_len_reg       <= '0;
            gathered_reg      <= '0;
            given_count_reg   <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (fire)
            begin
                bytes_pending_reg <= bytes_pending_next;
                seq_len_reg       <= seq_len_next;
                gathered_reg      <= gathered_next;
                given_count_reg   <= given_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hold_byte_reg <= in_byte;
    end

    a_idle_state_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_pending_reg == '0) |-> (seq_len_reg == '0 && gathered_reg == '0))
        else $error("no sequence pending but length or gathered bits left over");

    a_pending_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_pending_reg != '0) |-> (bytes_pending_reg < seq_len_reg))
        else $error("pending count not below sequence length");

    a_end_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && l_end) |=> (given_count_reg == '0))
        else $error("string end did not clear the count");

endmodule

// ----- hw/rtl/utf8sd_outq.sv -----
// Small result queue: takes up to two results per cycle, delivers one beat per cycle while the consumer is ready.
// Depends on utf8sd_pkg.
module utf8sd_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  utf8sd_pkg::push_t   push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output utf8sd_pkg::result_t out_data
);
    import utf8sd_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    result_t            entries_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entries_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Room for the worst case of two results, judged before this cycle's pop.
    assign room      = (count_reg <= CNT_W'(QDEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entries_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entries_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
    end

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("results pushed without room in the queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg == rd_ptr_reg + count_reg[PTR_W-1:0])
        else $error("queue pointers disagree with the count");

endmodule

// ----- hw/rtl/utf8_stream_decoder.sv -----
// UTF-8 stream decoder. An accepted byte is held in the core's hold register and its
// results then go into the result queue. Throughput: one byte per cycle while each byte
// gives at most one result and the consumer is ready; a byte that gives two results
// takes two output beats of the result queue. Reset (rst_n low, asynchronous): no
// sequence pending, count zero, queue empty, narrow_mode 0 and capacity_units 65535.
module utf8_stream_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    utf8sd_byte_if.sink                        text_in,
    utf8sd_res_if.source                       result_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [utf8sd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [utf8sd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [utf8sd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                               pready
);
    import utf8sd_pkg::*;

    // The data path has three parts. The register block holds the two settings.
    // The core registers each incoming beat and, in one shallow pass, resolves it
    // against the pending multi-byte sequence: a finished or broken sequence yields
    // a point or the '?' mark, and the byte itself may then act as a lead, a plain
    // ASCII point, a stray continuation or the string terminator. Both candidate
    // results pass the capacity check in order and are pushed together.
    // The result queue parts the output handshake from the core, so the core keeps
    // taking bytes while earlier results wait for the consumer, as long as the queue has room.

    cfg_t    cfg;
    push_t   push;
    logic    room;
    result_t q_data;

    utf8sd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    utf8sd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (text_in.valid),
        .in_ready (text_in.ready),
        .in_byte  (text_in.text_byte),
        .room     (room),
        .push     (push)
    );

    utf8sd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .out_data  (q_data)
    );

    // The end-of-run flag marks the final result of each input byte.
    assign result_out.code_point    = q_data.code_point;
    assign result_out.string_end    = q_data.string_end;
    assign result_out.units_written = q_data.units_written;
    assign result_out.last_of_run   = q_data.last_of_run;

endmodule
